### rtl/core/pst_pkg.sv
// Shared types, codes and sizes of the process signal state table.
`default_nettype none
package pst_pkg;

   localparam int SLOT_COUNT   = 64;
   localparam int SIGNAL_COUNT = 64;
   localparam int ACTION_BITS  = 64;

   localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SIG_W     = $clog2(SIGNAL_COUNT);
   localparam int ACT_DEPTH = SLOT_COUNT * SIGNAL_COUNT;
   localparam int ADDR_W    = $clog2(ACT_DEPTH);

   localparam logic [7:0]  SIG_KILL    = 8'd9;
   localparam logic [7:0]  SIG_STOP    = 8'd19;
   localparam logic [63:0] UNBLOCKABLE = (64'd1 << SIG_KILL) | (64'd1 << SIG_STOP);

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_NO_SLOT = 2'd2
   } status_type;

   typedef enum logic {
      OP_ACTION = 1'b0,
      OP_MASK   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      MODE_BLOCK   = 2'd0,
      MODE_UNBLOCK = 2'd1,
      MODE_SET     = 2'd2,
      MODE_BAD     = 2'd3
   } mask_mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_SELECT,
      ST_ACTION,
      ST_DONE
   } state_type;

   // broadcast from the sequencer to every slot cell
   typedef struct packed {
      logic [31:0] pid;
      logic        claim_en;
      logic        mask_we;
      logic [63:0] new_mask;
   } cell_ctrl_type;

   // what the row of cells reports back
   typedef struct packed {
      logic              hit_any;
      logic              full;
      logic [SLOT_W-1:0] slot_idx;
      logic [63:0]       old_mask;
   } row_status_type;

endpackage
`default_nettype wire

### rtl/core/process_signal_state_table_core.sv
// Top level of the process signal state table: sequencer, action memory, response register.
//
// Request channel (req_*): one word per call names a process id and either
// reads/replaces one signal's action word (operation 0) or reads/changes the
// process's 64-bit blocked mask (operation 1). Response channel (rsp_*):
// exactly one word per request, in order, with status, old action, old mask.
// From accept, a mask call or a reject passes the LOOK, SELECT and DONE
// states before rsp_valid; an action call also passes ACTION (the action memory read).
// One request is in flight at a time; a new one is accepted in the cycle
// after the previous result moves into the response register, so no new
// request is taken before the last one is through the slot lookup and the
// memory read-modify-write.
// After reset the action memory is swept to zero, one entry a cycle, over all
// SLOT_COUNT*SIGNAL_COUNT entries (4096); req_ready stays low meanwhile.
// Slot state (used flags, masks) clears at once on reset; the ids are not reset.
// A stalled receiver holds the response register; the next request may be
// taken and worked on, and it waits in its last stage until the register frees.
`default_nettype none
module process_signal_state_table_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [31:0] req_process_id,
   input  wire logic [7:0]  req_signal_number,
   input  wire logic        req_has_new_action,
   input  wire logic [63:0] req_new_action,
   input  wire logic [1:0]  req_mask_mode,
   input  wire logic        req_has_set,
   input  wire logic [63:0] req_set_mask,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_old_action,
   output logic [63:0]      rsp_old_mask
);

   localparam int AB = pst_pkg::ACTION_BITS;
   localparam int AW = pst_pkg::ADDR_W;

   // sequencer state
   pst_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;

   // captured request word
   logic                   op_ff, op_in;
   logic [31:0]            pid_ff, pid_in;
   logic                   sig_ok_ff, sig_ok_in;
   logic [pst_pkg::SIG_W-1:0] sig_idx_ff, sig_idx_in;
   logic                   has_act_ff, has_act_in;
   logic [AB-1:0]          act_ff, act_in;
   logic [1:0]             mode_ff, mode_in;
   logic                   has_set_ff, has_set_in;
   logic [63:0]            set_ff, set_in;

   // result being built
   pst_pkg::status_type    res_status_ff, res_status_in;
   logic [AB-1:0]          res_action_ff, res_action_in;
   logic [63:0]            res_mask_ff, res_mask_in;
   logic [AW-1:0]          addr_ff, addr_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   pst_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [AB-1:0]          rsp_action_ff, rsp_action_in;
   logic [63:0]            rsp_mask_ff, rsp_mask_in;

   // action memory
   logic [AB-1:0]          act_mem [pst_pkg::ACT_DEPTH];
   logic [AB-1:0]          rd_data_ff;
   logic                   mem_we, mem_re;
   logic [AW-1:0]          mem_waddr, mem_raddr;
   logic [AB-1:0]          mem_wdata;

   // slot row
   pst_pkg::cell_ctrl_type  cell_ctrl;
   pst_pkg::row_status_type row_status;

   logic                   accept;
   logic                   out_free;
   logic                   sig_ok_now;
   logic [AW-1:0]          lookup_addr;
   logic [63:0]            merged_mask;

   pst_slot_row u_row (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (cell_ctrl),
      .status (row_status)
   );

   assign req_ready = (state_ff == pst_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign sig_ok_now = (req_signal_number != 8'd0)
                       && (req_signal_number <= 8'(pst_pkg::SIGNAL_COUNT))
                       && (req_signal_number != pst_pkg::SIG_KILL)
                       && (req_signal_number != pst_pkg::SIG_STOP);

   // entry = slot * SIGNAL_COUNT + (signal - 1)
   assign lookup_addr = AW'(row_status.slot_idx) * AW'(pst_pkg::SIGNAL_COUNT)
                        + AW'(sig_idx_ff);

   always_comb begin
      case (pst_pkg::mask_mode_type'(mode_ff))
         pst_pkg::MODE_BLOCK:   merged_mask = row_status.old_mask | set_ff;
         pst_pkg::MODE_UNBLOCK: merged_mask = row_status.old_mask & ~set_ff;
         pst_pkg::MODE_SET:     merged_mask = set_ff;
         default:               merged_mask = row_status.old_mask;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      op_in         = op_ff;
      pid_in        = pid_ff;
      sig_ok_in     = sig_ok_ff;
      sig_idx_in    = sig_idx_ff;
      has_act_in    = has_act_ff;
      act_in        = act_ff;
      mode_in       = mode_ff;
      has_set_in    = has_set_ff;
      set_in        = set_ff;
      res_status_in = res_status_ff;
      res_action_in = res_action_ff;
      res_mask_in   = res_mask_ff;
      addr_in       = addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_action_in = rsp_action_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = addr_ff;
      mem_raddr = lookup_addr;
      mem_wdata = act_ff;

      cell_ctrl.pid      = pid_ff;
      cell_ctrl.claim_en = 1'b0;
      cell_ctrl.mask_we  = 1'b0;
      cell_ctrl.new_mask = merged_mask & ~pst_pkg::UNBLOCKABLE;

      case (state_ff)
         pst_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(pst_pkg::ACT_DEPTH - 1)) begin
               state_in = pst_pkg::ST_IDLE;
            end
         end
         pst_pkg::ST_IDLE: begin
            if (accept) begin
               op_in      = req_operation;
               pid_in     = req_process_id;
               sig_ok_in  = sig_ok_now;
               sig_idx_in = pst_pkg::SIG_W'(req_signal_number - 8'd1);
               has_act_in = req_has_new_action;
               act_in     = req_new_action[AB-1:0];
               mode_in    = req_mask_mode;
               has_set_in = req_has_set;
               set_in     = req_set_mask;
               state_in   = pst_pkg::ST_LOOK;
            end
         end
         pst_pkg::ST_LOOK: begin
            // cells register their id compare this cycle
            state_in = pst_pkg::ST_SELECT;
         end
         pst_pkg::ST_SELECT: begin
            res_status_in = pst_pkg::STATUS_OK;
            res_action_in = '0;
            res_mask_in   = 64'd0;
            if (op_ff == pst_pkg::OP_ACTION && !sig_ok_ff) begin
               res_status_in = pst_pkg::STATUS_INVALID;
               state_in      = pst_pkg::ST_DONE;
            end else if (!row_status.hit_any && row_status.full) begin
               res_status_in = pst_pkg::STATUS_NO_SLOT;
               state_in      = pst_pkg::ST_DONE;
            end else begin
               cell_ctrl.claim_en = !row_status.hit_any;
               if (op_ff == pst_pkg::OP_ACTION) begin
                  mem_re   = 1'b1;
                  addr_in  = lookup_addr;
                  state_in = pst_pkg::ST_ACTION;
               end else begin
                  res_mask_in = row_status.old_mask;
                  if (has_set_ff) begin
                     if (mode_ff == pst_pkg::MODE_BAD) begin
                        res_status_in = pst_pkg::STATUS_INVALID;
                     end else begin
                        cell_ctrl.mask_we = 1'b1;
                     end
                  end
                  state_in = pst_pkg::ST_DONE;
               end
            end
         end
         pst_pkg::ST_ACTION: begin
            res_action_in = rd_data_ff;
            mem_we        = has_act_ff;
            state_in      = pst_pkg::ST_DONE;
         end
         pst_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_action_in = res_action_ff;
               rsp_mask_in   = res_mask_ff;
               state_in      = pst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pst_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pid_ff        <= pid_in;
      sig_ok_ff     <= sig_ok_in;
      sig_idx_ff    <= sig_idx_in;
      has_act_ff    <= has_act_in;
      act_ff        <= act_in;
      mode_ff       <= mode_in;
      has_set_ff    <= has_set_in;
      set_ff        <= set_in;
      res_status_ff <= res_status_in;
      res_action_ff <= res_action_in;
      res_mask_ff   <= res_mask_in;
      addr_ff       <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_action_ff <= rsp_action_in;
      rsp_mask_ff   <= rsp_mask_in;
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         act_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= act_mem[mem_raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_old_action = 64'(rsp_action_ff);
   assign rsp_old_mask   = rsp_mask_ff;

endmodule
`default_nettype wire

### rtl/core/pst_cell.sv
// One slot cell: holds a process id, its used flag and its blocked mask.
`default_nettype none
module pst_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pst_pkg::cell_ctrl_type ctrl,
   input  wire logic                   hit_any,
   input  wire logic                   grant_in,
   output logic                        grant_out,
   output logic                        match,
   output logic                        sel,
   output logic [63:0]                 sel_mask
);

   logic        used_ff;
   logic        used_in;
   logic [31:0] pid_ff;
   logic [31:0] pid_in;
   logic [63:0] mask_ff;
   logic [63:0] mask_in;
   logic        match_ff;
   logic        match_in;
   logic        claim_here;

   // free-slot token ripples past used cells; first free cell keeps it
   assign claim_here = grant_in & ~used_ff;
   assign grant_out  = grant_in & used_ff;

   assign match_in = used_ff & (pid_ff == ctrl.pid);
   assign match    = match_ff;
   assign sel      = hit_any ? match_ff : claim_here;
   assign sel_mask = sel ? mask_ff : 64'd0;

   always_comb begin
      used_in = used_ff;
      pid_in  = pid_ff;
      mask_in = mask_ff;
      if (ctrl.claim_en && claim_here) begin
         used_in = 1'b1;
         pid_in  = ctrl.pid;
      end
      if (ctrl.mask_we && sel) begin
         mask_in = ctrl.new_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         mask_ff  <= 64'd0;
         match_ff <= 1'b0;
      end else begin
         used_ff  <= used_in;
         mask_ff  <= mask_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff <= pid_in;
   end

endmodule
`default_nettype wire

### rtl/core/pst_slot_row.sv
// Row of slot cells with the free-slot chain and the selected-slot readout.
`default_nettype none
module pst_slot_row (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pst_pkg::cell_ctrl_type  ctrl,
   output pst_pkg::row_status_type      status
);

   logic [pst_pkg::SLOT_COUNT:0]   grant;
   logic [pst_pkg::SLOT_COUNT-1:0] match;
   logic [pst_pkg::SLOT_COUNT-1:0] sel;
   logic [63:0]                    sel_mask [pst_pkg::SLOT_COUNT];
   logic                           hit_any;

   assign grant[0] = 1'b1;
   assign hit_any  = |match;

   for (genvar i = 0; i < pst_pkg::SLOT_COUNT; i++) begin : g_cell
      pst_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .hit_any   (hit_any),
         .grant_in  (grant[i]),
         .grant_out (grant[i+1]),
         .match     (match[i]),
         .sel       (sel[i]),
         .sel_mask  (sel_mask[i])
      );
   end

   // at most one cell is selected, so plain OR merges index and mask
   always_comb begin
      status.hit_any  = hit_any;
      status.full     = grant[pst_pkg::SLOT_COUNT];
      status.slot_idx = '0;
      status.old_mask = 64'd0;
      for (int i = 0; i < pst_pkg::SLOT_COUNT; i++) begin
         status.slot_idx = status.slot_idx
                           | (sel[i] ? pst_pkg::SLOT_W'(i) : pst_pkg::SLOT_W'(0));
         status.old_mask = status.old_mask | sel_mask[i];
      end
   end

endmodule
`default_nettype wire
